// ===== design/lj_pkg.sv =====
`timescale 1ns / 1ps

package lj_pkg;

    localparam logic [63:0] CAP = 64'h8000_0000_0000_0000;

    localparam logic [1:0] CFG_BOX_LENGTH    = 2'd0;
    localparam logic [1:0] CFG_CUTOFF_RADIUS = 2'd1;

    localparam logic [23:0] BOX_RESET    = 24'd483819;
    localparam logic [23:0] CUTOFF_RESET = 24'd163840;

    localparam int unsigned RECIP_STAGES = 64;
    localparam int unsigned PIPE_LAT     = 3 + RECIP_STAGES + 12;

    typedef struct packed {
        logic             in_cut;
        logic             zero;
        logic             small_r;
        logic [2:0]       dneg;
        logic [2:0][23:0] dm;
    } t_sb;

    function automatic logic [32:0] pack32(input logic neg, input logic [63:0] mag);
        logic [32:0] res;
        if (neg) begin
            if (mag > 64'h0000_0000_8000_0000) begin
                res = {1'b1, 32'h8000_0000};
            end else begin
                res = {1'b0, 32'h0 - mag[31:0]};
            end
        end else begin
            if (mag > 64'h0000_0000_7FFF_FFFF) begin
                res = {1'b1, 32'h7FFF_FFFF};
            end else begin
                res = {1'b0, mag[31:0]};
            end
        end
        return res;
    endfunction

endpackage

// ===== design/lj_dly.sv =====
`timescale 1ns / 1ps

module lj_dly #(
    parameter int unsigned W = 1,
    parameter int unsigned N = 1
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);

    logic [W-1:0] r_sr [N];

    always_ff @(posedge i_clk) begin
        r_sr[0] <= i_d;
        for (int k = 1; k < N; k++) begin
            r_sr[k] <= r_sr[k-1];
        end
    end

    assign o_d = r_sr[N-1];

endmodule

// ===== design/lj_recip.sv =====
`timescale 1ns / 1ps

module lj_recip import lj_pkg::*; (
    input  logic        i_clk,
    input  logic [47:0] i_den,
    output logic [63:0] o_quo
);

    logic [47:0] r_rem [RECIP_STAGES-1];
    logic [47:0] r_den [RECIP_STAGES-1];
    logic [63:0] r_quo [RECIP_STAGES];

    logic [47:0] a_rem [RECIP_STAGES];
    logic [47:0] a_den [RECIP_STAGES];
    logic [63:0] a_quo [RECIP_STAGES];
    logic [48:0] shl   [RECIP_STAGES];
    logic [48:0] dif   [RECIP_STAGES];
    logic [RECIP_STAGES-1:0] ge;
    logic [47:0] n_rem [RECIP_STAGES-1];
    logic [63:0] n_quo [RECIP_STAGES];

    // restoring division of 2^64, one quotient bit per stage
    always_comb begin
        a_rem[0] = 48'd1;
        a_den[0] = i_den;
        a_quo[0] = '0;
        for (int k = 1; k < RECIP_STAGES; k++) begin
            a_rem[k] = r_rem[k-1];
            a_den[k] = r_den[k-1];
            a_quo[k] = r_quo[k-1];
        end
        for (int k = 0; k < RECIP_STAGES; k++) begin
            shl[k]   = {a_rem[k], 1'b0};
            dif[k]   = shl[k] - {1'b0, a_den[k]};
            ge[k]    = (shl[k] >= {1'b0, a_den[k]});
            n_quo[k] = {a_quo[k][62:0], ge[k]};
        end
        for (int k = 0; k < RECIP_STAGES - 1; k++) begin
            n_rem[k] = ge[k] ? dif[k][47:0] : shl[k][47:0];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < RECIP_STAGES - 1; k++) begin
            r_rem[k] <= n_rem[k];
            r_den[k] <= a_den[k];
        end
        for (int k = 0; k < RECIP_STAGES; k++) begin
            r_quo[k] <= n_quo[k];
        end
    end

    assign o_quo = r_quo[RECIP_STAGES-1];

endmodule

// ===== design/lj_mulq.sv =====
`timescale 1ns / 1ps

module lj_mulq import lj_pkg::*; (
    input  logic        i_clk,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_p
);

    logic [31:0] ah, al, bh, bl;
    logic [63:0] r_hh, r_hl, r_lh, r_ll;
    logic [96:0] sum;
    logic [63:0] r_p;

    assign ah = i_a[63:32];
    assign al = i_a[31:0];
    assign bh = i_b[63:32];
    assign bl = i_b[31:0];

    always_ff @(posedge i_clk) begin
        r_hh <= ah * bh;
        r_hl <= ah * bl;
        r_lh <= al * bh;
        r_ll <= al * bl;
    end

    // floor(a*b / 2^32), clamped at 2^63
    assign sum = {1'b0, r_hh, 32'b0} + {33'b0, r_hl} + {33'b0, r_lh}
               + {65'b0, r_ll[63:32]};

    always_ff @(posedge i_clk) begin
        r_p <= (sum >= {33'b0, CAP}) ? CAP : sum[63:0];
    end

    assign o_p = r_p;

endmodule

// ===== design/lj_pair_force_min_image.sv =====
`timescale 1ns / 1ps

// Lennard-Jones pair force with minimum image and cutoff. One particle pair
// is taken per clock (o_busy stays low) and its result appears on o_valid
// for one cycle; the receiver cannot stall, so it must take every beat as it
// comes. Most of the pipeline is the 64-stage pipelined reciprocal of r^2
// and the chain of fixed-point powers behind it. Box length and cutoff are
// written through i_cfg_we/i_cfg_addr/i_cfg_wdata; the user must write them
// only while no pair is in flight, as the block itself does not enforce it.

module lj_pair_force_min_image import lj_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_addr,
    input  logic [23:0]        i_cfg_wdata,
    input  logic [23:0]        i_pos_i_x,
    input  logic [23:0]        i_pos_i_y,
    input  logic [23:0]        i_pos_i_z,
    input  logic [23:0]        i_pos_j_x,
    input  logic [23:0]        i_pos_j_y,
    input  logic [23:0]        i_pos_j_z,
    output logic               o_valid,
    output logic signed [31:0] o_accel_x,
    output logic signed [31:0] o_accel_y,
    output logic signed [31:0] o_accel_z,
    output logic signed [31:0] o_pair_energy,
    output logic               o_within_cutoff,
    output logic               o_saturated
);

    logic [23:0] r_box, r_cut;
    logic [47:0] r_cut_sq;
    logic [PIPE_LAT-1:0] r_vld;
    logic acc;

    logic [2:0][23:0] pi, pj;
    logic [2:0][25:0] dif, dmag, n_d;
    logic [2:0][25:0] r_d1;
    logic [2:0][25:0] dabs;
    logic [2:0]       r_dneg2;
    logic [2:0][23:0] r_dm2;
    logic [2:0][47:0] r_sq2;
    logic [49:0]      rsq;
    t_sb              r_sb3;
    logic [47:0]      r_den3;

    t_sb         sb_p0, sb_p9, sb_p11;
    logic [63:0] quo, s, s_d2, s_d6;
    logic [63:0] s2, s3, s4, s6, s7, s3_d, s4_d, s6_d;

    logic [64:0] qd, qabs, ed, eabs;
    logic [49:0] em;
    logic        n_qneg;
    logic [63:0] n_qmag;
    logic [32:0] n_en;
    logic        r_qneg9;
    logic [63:0] r_qmag9;
    logic [32:0] r_en9;
    logic        qneg11;
    logic [32:0] en11;

    logic [2:0][29:0] m48;
    logic [2:0][63:0] am;
    logic [2:0][32:0] pk;
    logic [2:0][31:0] r_acc;
    logic [31:0]      r_en;
    logic             r_within, r_sat;

    assign o_busy = 1'b0;
    assign acc    = i_start & ~o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box <= BOX_RESET;
            r_cut <= CUTOFF_RESET;
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_LAT-2:0], acc};
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_BOX_LENGTH:    r_box <= i_cfg_wdata;
                    CFG_CUTOFF_RADIUS: r_cut <= i_cfg_wdata;
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cut_sq <= r_cut * r_cut;
    end

    // minimum-image fold
    assign pi = {i_pos_i_z, i_pos_i_y, i_pos_i_x};
    assign pj = {i_pos_j_z, i_pos_j_y, i_pos_j_x};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dif[k]  = {2'b0, pi[k]} - {2'b0, pj[k]};
            dmag[k] = dif[k][25] ? (26'd0 - dif[k]) : dif[k];
            if ({dmag[k][24:0], 1'b0} > {2'b0, r_box}) begin
                n_d[k] = dif[k][25] ? (dif[k] + {2'b0, r_box}) : (dif[k] - {2'b0, r_box});
            end else begin
                n_d[k] = dif[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_d1 <= n_d;
    end

    // squares
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dabs[k] = r_d1[k][25] ? (26'd0 - r_d1[k]) : r_d1[k];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_dneg2[k] <= r_d1[k][25];
            r_dm2[k]   <= dabs[k][23:0];
            r_sq2[k]   <= dabs[k][23:0] * dabs[k][23:0];
        end
    end

    // r^2 and cutoff test
    assign rsq = {2'b0, r_sq2[0]} + {2'b0, r_sq2[1]} + {2'b0, r_sq2[2]};

    always_ff @(posedge i_clk) begin
        r_sb3.in_cut  <= (rsq < {2'b0, r_cut_sq});
        r_sb3.zero    <= (rsq == 50'd0);
        r_sb3.small_r <= (rsq <= 50'd2);
        r_sb3.dneg    <= r_dneg2;
        r_sb3.dm      <= r_dm2;
        r_den3        <= rsq[47:0];
    end

    lj_recip u_recip (
        .i_clk (i_clk),
        .i_den (r_den3),
        .o_quo (quo)
    );

    lj_dly #(.W($bits(t_sb)), .N(RECIP_STAGES)) u_sb_p0 (
        .i_clk (i_clk), .i_d (r_sb3), .o_d (sb_p0)
    );

    assign s = sb_p0.small_r ? CAP : quo;

    // powers of 1/r^2
    lj_mulq u_s2 (.i_clk(i_clk), .i_a(s),  .i_b(s),    .o_p(s2));
    lj_dly #(.W(64), .N(2)) u_s_d2 (.i_clk(i_clk), .i_d(s), .o_d(s_d2));
    lj_mulq u_s3 (.i_clk(i_clk), .i_a(s2), .i_b(s_d2), .o_p(s3));
    lj_mulq u_s4 (.i_clk(i_clk), .i_a(s2), .i_b(s2),   .o_p(s4));
    lj_dly #(.W(64), .N(4)) u_s_d6 (.i_clk(i_clk), .i_d(s_d2), .o_d(s_d6));
    lj_mulq u_s6 (.i_clk(i_clk), .i_a(s3), .i_b(s3),   .o_p(s6));
    lj_mulq u_s7 (.i_clk(i_clk), .i_a(s6), .i_b(s_d6), .o_p(s7));
    lj_dly #(.W(64), .N(4)) u_s3_d (.i_clk(i_clk), .i_d(s3), .o_d(s3_d));
    lj_dly #(.W(64), .N(4)) u_s4_d (.i_clk(i_clk), .i_d(s4), .o_d(s4_d));
    lj_dly #(.W(64), .N(2)) u_s6_d (.i_clk(i_clk), .i_d(s6), .o_d(s6_d));

    // force factor and energy
    always_comb begin
        qd   = {1'b0, s7} - {2'b0, s4_d[63:1]};
        qabs = qd[64] ? (65'd0 - qd) : qd;
        if (s7 >= CAP) begin
            n_qneg = 1'b0;
            n_qmag = CAP;
        end else begin
            n_qneg = qd[64];
            n_qmag = qabs[63:0];
        end
        ed   = {1'b0, s6_d} - {1'b0, s3_d};
        eabs = ed[64] ? (65'd0 - ed) : ed;
        em   = eabs[63:14];
        if (s6_d >= CAP) begin
            n_en = pack32(1'b0, CAP);
        end else begin
            n_en = pack32(ed[64] && (em != 50'd0), {14'b0, em});
        end
    end

    always_ff @(posedge i_clk) begin
        r_qneg9 <= n_qneg;
        r_qmag9 <= n_qmag;
        r_en9   <= n_en;
    end

    lj_dly #(.W($bits(t_sb)), .N(9)) u_sb_p9 (
        .i_clk (i_clk), .i_d (sb_p0), .o_d (sb_p9)
    );

    // accelerations
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            m48[k] = {1'b0, sb_p9.dm[k], 5'b0} + {2'b0, sb_p9.dm[k], 4'b0};
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_acc
        lj_mulq u_acc (
            .i_clk (i_clk),
            .i_a   (r_qmag9),
            .i_b   ({34'b0, m48[k]}),
            .o_p   (am[k])
        );
    end

    lj_dly #(.W($bits(t_sb)), .N(2)) u_sb_p11 (
        .i_clk (i_clk), .i_d (sb_p9), .o_d (sb_p11)
    );
    lj_dly #(.W(1), .N(2)) u_qneg (.i_clk(i_clk), .i_d(r_qneg9), .o_d(qneg11));
    lj_dly #(.W(33), .N(2)) u_en (.i_clk(i_clk), .i_d(r_en9), .o_d(en11));

    // output beat
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pk[k] = pack32(qneg11 ^ sb_p11.dneg[k], am[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (sb_p11.in_cut) begin
            for (int k = 0; k < 3; k++) begin
                r_acc[k] <= pk[k][31:0];
            end
            r_en     <= en11[31:0];
            r_within <= 1'b1;
            r_sat    <= pk[0][32] | pk[1][32] | pk[2][32] | en11[32] | sb_p11.zero;
        end else begin
            r_acc    <= '0;
            r_en     <= '0;
            r_within <= 1'b0;
            r_sat    <= 1'b0;
        end
    end

    assign o_valid         = r_vld[PIPE_LAT-1];
    assign o_accel_x       = $signed(r_acc[0]);
    assign o_accel_y       = $signed(r_acc[1]);
    assign o_accel_z       = $signed(r_acc[2]);
    assign o_pair_energy   = $signed(r_en);
    assign o_within_cutoff = r_within;
    assign o_saturated     = r_sat;

endmodule

// ===== design/lj_chk.sv =====
`timescale 1ns / 1ps

module lj_chk import lj_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input logic               o_busy,
    input logic               o_valid,
    input logic signed [31:0] o_accel_x,
    input logic signed [31:0] o_accel_y,
    input logic signed [31:0] o_accel_z,
    input logic signed [31:0] o_pair_energy,
    input logic               o_within_cutoff,
    input logic               o_saturated
);

    // every accepted pair gives exactly one beat on o_valid
    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##PIPE_LAT o_valid)
        else $error("accepted pair produced no beat");

    a_lat_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, PIPE_LAT))
        else $error("beat without an accepted pair");

    // outside the cutoff everything is zero
    a_beyond: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_within_cutoff) |->
        (o_accel_x == 32'sd0 && o_accel_y == 32'sd0 && o_accel_z == 32'sd0
         && o_pair_energy == 32'sd0 && !o_saturated))
        else $error("nonzero result beyond cutoff");

    // the pipeline takes a pair every cycle
    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy)
        else $error("busy raised on a pipeline that never stalls");

endmodule

bind lj_pair_force_min_image lj_chk u_lj_chk (.*);
